### design/pomc_pkg.sv
// ----------------------------------------------------------------------------
// pomc_pkg
// Shared types and constants for the output mode controller.
// ----------------------------------------------------------------------------
package pomc_pkg;

  localparam int OUT_COUNT = 8;
  localparam logic [7:0] OUT_MASK = 8'((1 << OUT_COUNT) - 1);

  localparam int CHASE_W = 20;
  localparam int PULSE_W = 19;
  localparam int SPEED_W = 11;
  localparam int CFG_W   = 20;

  localparam logic [CHASE_W-1:0] CHASE_MAX   = '1;
  localparam logic [PULSE_W-1:0] PULSE_MAX   = '1;
  localparam logic [PULSE_W-1:0] HALF_NUM    = 19'd500000;
  localparam logic [PULSE_W-1:0] HALF_RESET  = 19'd2500;
  localparam logic [SPEED_W-1:0] SPEED_MIN   = 11'd1;
  localparam logic [SPEED_W-1:0] SPEED_MAX   = 11'd2000;
  localparam logic [CHASE_W-1:0] CHASE_RESET = 20'd250000;
  localparam logic [7:0]         CHASE_SEED  = 8'h01;

  // Output bit positions in stepper mode.
  localparam int PULSE_POS = 0;
  localparam int DIR_POS   = 1;
  localparam int ENA_POS   = 2;

  typedef enum logic [3:0] {
    ACT_TICK         = 4'd0,
    ACT_RUN_SET      = 4'd1,
    ACT_RUN_TOGGLE   = 4'd2,
    ACT_NEXT_MODE    = 4'd3,
    ACT_LATCH        = 4'd4,
    ACT_MODE_SET     = 4'd5,
    ACT_MANUAL_WRITE = 4'd6,
    ACT_MANUAL_BIT   = 4'd7,
    ACT_STEP_START   = 4'd8,
    ACT_STEP_STOP    = 4'd9,
    ACT_STEP_ENABLE  = 4'd10,
    ACT_STEP_DIR     = 4'd11
  } action_t;

  typedef enum logic [2:0] {
    MODE_MIRROR  = 3'd0,
    MODE_LATCH   = 3'd1,
    MODE_CHASE   = 3'd2,
    MODE_MANUAL  = 3'd3,
    MODE_STEPPER = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_SPEED      = 2'd0,
    REG_CHASE      = 2'd1,
    REG_ENA_POLART = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] plc_inputs;
    logic [7:0] value;
    logic [3:0] bit_index;
  } item_t;

  typedef struct packed {
    logic [7:0] out_bits;
    logic       running;
    logic [2:0] mode_now;
    logic       stepping;
    logic       cmd_error;
  } result_t;

  typedef struct packed {
    logic               run_flag;
    mode_t              mode_sel;
    logic [7:0]         latched_byte;
    logic [7:0]         manual_byte;
    logic [7:0]         chase_byte;
    logic [CHASE_W-1:0] chase_elapsed;
    logic               stepper_enabled;
    logic               direction_cw;
    logic               pulse_out;
    logic [PULSE_W-1:0] pulse_elapsed;
  } ctrl_state_t;

  localparam ctrl_state_t STATE_RESET = '{
    run_flag:        1'b0,
    mode_sel:        MODE_MIRROR,
    latched_byte:    8'h00,
    manual_byte:     8'h00,
    chase_byte:      CHASE_SEED,
    chase_elapsed:   '0,
    stepper_enabled: 1'b1,
    direction_cw:    1'b1,
    pulse_out:       1'b0,
    pulse_elapsed:   '0
  };

endpackage

### design/plc_output_mode_controller.sv
// ----------------------------------------------------------------------------
// plc_output_mode_controller
// Eight-output mode controller with mirror, latch, chase, manual and
// step/dir pulse modes, driven by decoded actions and microsecond ticks.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the s_ side carries one action (s_tuser) and its operands
// (s_tdata). Every accepted item yields exactly one result transfer on the
// m_ side with the output drive value and status flags after that item.
// The accepting edge loads the input register; the result register and
// m_tvalid load on a later edge, once the result register is free, after one
// pass through the update logic.
// One item per clock unless m_tready or a divide stalls; ticks may arrive back to back.
// The input accepts a new item while a finished result waits, as long as the
// result register is free or being emptied in the same cycle; a stall on
// m_tready backs up into s_tready once both registers are full.
// Configuration writes go through cfg_we/cfg_index/cfg_data. Writing the
// speed register starts a bit-serial divide of 500000 by the speed; s_tready
// is low during the write and while the divide runs, until the half period settles.
// Reset is synchronous and returns the controller state and configuration
// registers to their defaults (speed 200, chase period 250000, enable active
// high); the reset half period of 2500 is loaded directly, so no divide runs after reset.
// ----------------------------------------------------------------------------
module plc_output_mode_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // plc_inputs[7:0], value[15:8], bit_index[19:16], zero pad
  input  logic [3:0]  s_tuser,   // action[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_bits[7:0], running[8], mode_now[11:9],
                                 // stepping[12], cmd_error[13], zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [pomc_pkg::CFG_W-1:0] cfg_data
);
  import pomc_pkg::*;

  logic               in_valid;
  item_t              in_item;
  result_t            out_res;
  result_t            core_res;
  logic               out_ready;
  logic               fire;
  logic               speed_wr;
  logic               div_busy;
  logic [PULSE_W-1:0] half_period;
  logic [CHASE_W-1:0] chase_period;
  logic               ena_active_high;

  assign speed_wr  = cfg_we && cfg_index == REG_SPEED;
  assign out_ready = !m_tvalid || m_tready;
  assign fire      = in_valid && out_ready;
  assign s_tready  = !div_busy && !speed_wr && (!in_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action     <= s_tuser;
      in_item.plc_inputs <= s_tdata[7:0];
      in_item.value      <= s_tdata[15:8];
      in_item.bit_index  <= s_tdata[19:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chase_period    <= CHASE_RESET;
      ena_active_high <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CHASE:      chase_period    <= cfg_data[CHASE_W-1:0];
        REG_ENA_POLART: ena_active_high <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  pomc_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (speed_wr),
    .speed       (cfg_data[SPEED_W-1:0]),
    .busy        (div_busy),
    .half_period (half_period)
  );

  pomc_core u_core (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .item            (in_item),
    .pulse_restart   (speed_wr),
    .chase_period    (chase_period),
    .ena_active_high (ena_active_high),
    .half_period     (half_period),
    .result          (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = {2'b00, out_res.cmd_error, out_res.stepping, out_res.mode_now,
                    out_res.running, out_res.out_bits};

  a_no_accept_while_dividing: assert property (
    @(posedge clk) disable iff (rst) div_busy |-> !(s_tvalid && s_tready)
  ) else $error("item accepted while half period is being computed");

  a_fire_gives_result: assert property (
    @(posedge clk) disable iff (rst) fire |=> m_tvalid
  ) else $error("processed item did not produce a result");

  a_speed_write_starts_divide: assert property (
    @(posedge clk) disable iff (rst) (!rst && speed_wr) |=> div_busy
  ) else $error("speed write did not start the divider");

  a_no_fire_while_dividing: assert property (
    @(posedge clk) disable iff (rst) (div_busy && !$past(fire)) |-> !in_valid || fire
                                     || $past(in_valid)
  ) else $error("input register filled during a divide");

endmodule

### design/pomc_div.sv
// ----------------------------------------------------------------------------
// pomc_div
// Bit-serial restoring divider that derives the stepper half period from the
// pulse rate: half_period = 500000 / clamp(speed), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pomc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pomc_pkg::SPEED_W-1:0]     speed,
  output logic                             busy,
  output logic [pomc_pkg::PULSE_W-1:0]     half_period
);
  import pomc_pkg::*;

  localparam int CNT_W = $clog2(PULSE_W);

  logic [SPEED_W-1:0] divisor;
  logic [SPEED_W-1:0] rem;
  logic [PULSE_W-1:0] quot;
  logic [CNT_W-1:0]   cnt;

  logic [SPEED_W-1:0] speed_clamped;
  logic [SPEED_W:0]   trial;
  logic               take;
  logic [SPEED_W-1:0] rem_next;
  logic [PULSE_W-1:0] quot_next;

  always_comb begin
    if (speed < SPEED_MIN) begin
      speed_clamped = SPEED_MIN;
    end else if (speed > SPEED_MAX) begin
      speed_clamped = SPEED_MAX;
    end else begin
      speed_clamped = speed;
    end
  end

  always_comb begin
    trial     = {rem, HALF_NUM[cnt]};
    take      = trial >= {1'b0, divisor};
    rem_next  = take ? SPEED_W'(trial - {1'b0, divisor}) : trial[SPEED_W-1:0];
    quot_next = {quot[PULSE_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      half_period <= HALF_RESET;
      cnt         <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(PULSE_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy        <= 1'b0;
        half_period <= quot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      divisor <= speed_clamped;
      rem     <= '0;
      quot    <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      quot <= quot_next;
    end
  end

endmodule

### design/pomc_core.sv
// ----------------------------------------------------------------------------
// pomc_core
// Controller state and the single-pass update that applies one item and
// forms its result.
// ----------------------------------------------------------------------------
module pomc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          fire,
  input  pomc_pkg::item_t               item,
  input  logic                          pulse_restart,
  input  logic [pomc_pkg::CHASE_W-1:0]  chase_period,
  input  logic                          ena_active_high,
  input  logic [pomc_pkg::PULSE_W-1:0]  half_period,
  output pomc_pkg::result_t             result
);
  import pomc_pkg::*;

  ctrl_state_t st;
  ctrl_state_t st_next;

  logic       is_flag;
  logic       bad;
  logic [7:0] mask;
  logic [2:0] bit_pos;

  always_comb begin
    st_next = st;
    bad     = 1'b0;
    mask    = 8'h00;
    is_flag = item.value <= 8'd1;
    bit_pos = 3'(item.bit_index - 4'd1);

    unique case (action_t'(item.action))
      ACT_TICK: begin
        if (st.chase_elapsed != CHASE_MAX) st_next.chase_elapsed = st.chase_elapsed + 1'b1;
        if (st.pulse_elapsed != PULSE_MAX) st_next.pulse_elapsed = st.pulse_elapsed + 1'b1;
      end
      ACT_RUN_SET: begin
        if (!is_flag) begin
          bad = 1'b1;
        end else begin
          st_next.run_flag = item.value[0];
          if (item.value[0] && st.mode_sel == MODE_STEPPER) begin
            st_next.stepper_enabled = 1'b1;
            st_next.pulse_out       = 1'b0;
            st_next.pulse_elapsed   = '0;
          end
        end
      end
      ACT_RUN_TOGGLE: st_next.run_flag = ~st.run_flag;
      ACT_NEXT_MODE: begin
        if (st.mode_sel == MODE_MIRROR) begin
          st_next.mode_sel = MODE_LATCH;
        end else if (st.mode_sel == MODE_LATCH) begin
          st_next.mode_sel = MODE_CHASE;
        end else begin
          st_next.mode_sel = MODE_MIRROR;
        end
      end
      ACT_LATCH: st_next.latched_byte = item.plc_inputs;
      ACT_MODE_SET: begin
        if (item.value > 8'(MODE_STEPPER)) begin
          bad = 1'b1;
        end else begin
          st_next.mode_sel = mode_t'(item.value[2:0]);
        end
      end
      ACT_MANUAL_WRITE: begin
        st_next.manual_byte = item.value;
        st_next.mode_sel    = MODE_MANUAL;
        st_next.run_flag    = 1'b1;
      end
      ACT_MANUAL_BIT: begin
        if (item.bit_index == 4'd0 || item.bit_index > 4'(OUT_COUNT) || !is_flag) begin
          bad = 1'b1;
        end else begin
          st_next.manual_byte[bit_pos] = item.value[0];
          st_next.mode_sel = MODE_MANUAL;
          st_next.run_flag = 1'b1;
        end
      end
      ACT_STEP_START: begin
        st_next.mode_sel        = MODE_STEPPER;
        st_next.run_flag        = 1'b1;
        st_next.stepper_enabled = 1'b1;
        st_next.pulse_out       = 1'b0;
        st_next.pulse_elapsed   = '0;
      end
      ACT_STEP_STOP: begin
        st_next.mode_sel      = MODE_STEPPER;
        st_next.run_flag      = 1'b0;
        st_next.pulse_out     = 1'b0;
        st_next.pulse_elapsed = '0;
      end
      ACT_STEP_ENABLE: begin
        if (!is_flag) begin
          bad = 1'b1;
        end else begin
          st_next.mode_sel        = MODE_STEPPER;
          st_next.stepper_enabled = item.value[0];
          if (!item.value[0]) st_next.run_flag = 1'b0;
          st_next.pulse_out     = 1'b0;
          st_next.pulse_elapsed = '0;
        end
      end
      ACT_STEP_DIR: begin
        if (!is_flag) begin
          bad = 1'b1;
        end else begin
          st_next.mode_sel     = MODE_STEPPER;
          st_next.direction_cw = item.value[0];
        end
      end
      default: bad = 1'b1;
    endcase

    // Output stage of the same pass, on the updated state.
    if (st_next.run_flag) begin
      unique case (st_next.mode_sel)
        MODE_MIRROR: mask = item.plc_inputs;
        MODE_LATCH:  mask = st_next.latched_byte;
        MODE_CHASE: begin
          if (st_next.chase_elapsed >= chase_period) begin
            st_next.chase_elapsed = '0;
            st_next.chase_byte    = {st_next.chase_byte[6:0], st_next.chase_byte[7]};
          end
          mask = st_next.chase_byte;
        end
        MODE_MANUAL: mask = st_next.manual_byte;
        default:     mask = 8'h00;
      endcase
    end

    if (st_next.mode_sel == MODE_STEPPER) begin
      if (!st_next.run_flag || !st_next.stepper_enabled) begin
        st_next.pulse_out     = 1'b0;
        st_next.pulse_elapsed = '0;
      end else if (st_next.pulse_elapsed >= half_period) begin
        st_next.pulse_out     = ~st_next.pulse_out;
        st_next.pulse_elapsed = '0;
      end
      mask            = 8'h00;
      mask[PULSE_POS] = st_next.pulse_out;
      mask[DIR_POS]   = st_next.direction_cw;
      mask[ENA_POS]   = ~(st_next.stepper_enabled ^ ena_active_high);
    end

    result.out_bits  = mask & OUT_MASK;
    result.running   = st_next.run_flag;
    result.mode_now  = st_next.mode_sel;
    result.stepping  = st_next.run_flag && st_next.mode_sel == MODE_STEPPER
                       && st_next.stepper_enabled;
    result.cmd_error = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= st_next;
    end else if (pulse_restart) begin
      // A rate change starts the pulse over from a low level.
      st.pulse_out     <= 1'b0;
      st.pulse_elapsed <= '0;
    end
  end

endmodule

### test/plc_output_mode_controller_tb.sv
// ----------------------------------------------------------------------------
// plc_output_mode_controller_tb
// Self-checking stream testbench for the output mode controller. An internal
// predictor tracks run flag, mode, latch, manual and chase bytes and the
// step/dir pulse generator. It computes the expected result of every
// accepted item. Directed commands come first, then fast stepper pulse
// runs, then random traffic under several register settings, and last a
// long receiver stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module plc_output_mode_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pomc_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int REPORT_MAX  = 30;
  localparam logic [3:0] ACT_UNUSED_LO = 4'd12;
  localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata   = '0;   // plc_inputs[7:0], value[15:8], bit_index[19:16]
  logic [3:0]        s_tuser   = '0;   // action[3:0]
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [15:0]       m_tdata;          // out_bits[7:0], running[8], mode_now[11:9],
                                       // stepping[12], cmd_error[13]
  logic              cfg_we    = 1'b0;
  reg_idx_t          cfg_index = REG_SPEED;
  logic [CFG_W-1:0]  cfg_data  = '0;

  plc_output_mode_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // Predicted controller state and register copies.
  logic               run_on      = 1'b0;
  mode_t              cur_mode    = MODE_MIRROR;
  logic [7:0]         latch_val   = 8'h00;
  logic [7:0]         manual_val  = 8'h00;
  logic [7:0]         chase_val   = CHASE_SEED;
  logic [CHASE_W-1:0] chase_ticks = '0;
  logic               step_en     = 1'b1;
  logic               step_cw     = 1'b1;
  logic               step_level  = 1'b0;
  logic [PULSE_W-1:0] step_ticks  = '0;
  logic [PULSE_W-1:0] half_ticks  = HALF_RESET;
  logic [CHASE_W-1:0] chase_limit = CHASE_RESET;
  logic               ena_pol     = 1'b1;

  result_t outputs_due[$];

  int  errors        = 0;
  int  items_sent    = 0;
  int  results_seen  = 0;
  int  settings_used = 1;
  int  chase_steps   = 0;
  int  pulse_edges   = 0;
  int  cycle_count   = 0;
  bit  src_gaps      = 1'b1;
  bit  sink_gaps     = 1'b1;
  int  sink_hold     = 0;

  function automatic logic [PULSE_W-1:0] half_for_speed(logic [SPEED_W-1:0] speed);
    int s;
    s = speed;
    if (s < SPEED_MIN) s = SPEED_MIN;
    if (s > SPEED_MAX) s = SPEED_MAX;
    return PULSE_W'(int'(HALF_NUM) / s);
  endfunction

  function automatic void clear_pulse();
    step_level = 1'b0;
    step_ticks = '0;
  endfunction

  // Applies one item to the predicted state and returns the result it causes.
  function automatic result_t controller_outputs(logic [3:0] act, logic [7:0] pins,
                                                 logic [7:0] val, logic [3:0] idx);
    result_t    r;
    logic       bad;
    logic       flag_ok;
    logic [7:0] drive;
    bad     = 1'b0;
    drive   = 8'h00;
    flag_ok = (val <= 8'd1);
    case (act)
      ACT_TICK: begin
        if (chase_ticks != CHASE_MAX) chase_ticks++;
        if (step_ticks != PULSE_MAX) step_ticks++;
      end
      ACT_RUN_SET: begin
        if (!flag_ok) begin
          bad = 1'b1;
        end else begin
          run_on = val[0];
          if (run_on && cur_mode == MODE_STEPPER) begin
            step_en = 1'b1;
            clear_pulse();
          end
        end
      end
      ACT_RUN_TOGGLE: run_on = ~run_on;
      ACT_NEXT_MODE: begin
        case (cur_mode)
          MODE_MIRROR: cur_mode = MODE_LATCH;
          MODE_LATCH:  cur_mode = MODE_CHASE;
          default:     cur_mode = MODE_MIRROR;
        endcase
      end
      ACT_LATCH: latch_val = pins;
      ACT_MODE_SET: begin
        if (val > 8'(MODE_STEPPER)) bad = 1'b1;
        else cur_mode = mode_t'(val[2:0]);
      end
      ACT_MANUAL_WRITE: begin
        manual_val = val;
        cur_mode   = MODE_MANUAL;
        run_on     = 1'b1;
      end
      ACT_MANUAL_BIT: begin
        if (idx < 4'd1 || idx > OUT_COUNT || !flag_ok) begin
          bad = 1'b1;
        end else begin
          manual_val[idx - 4'd1] = val[0];
          cur_mode = MODE_MANUAL;
          run_on   = 1'b1;
        end
      end
      ACT_STEP_START: begin
        cur_mode = MODE_STEPPER;
        run_on   = 1'b1;
        step_en  = 1'b1;
        clear_pulse();
      end
      ACT_STEP_STOP: begin
        cur_mode = MODE_STEPPER;
        run_on   = 1'b0;
        clear_pulse();
      end
      ACT_STEP_ENABLE: begin
        if (!flag_ok) begin
          bad = 1'b1;
        end else begin
          cur_mode = MODE_STEPPER;
          step_en  = val[0];
          if (!val[0]) run_on = 1'b0;
          clear_pulse();
        end
      end
      ACT_STEP_DIR: begin
        if (!flag_ok) begin
          bad = 1'b1;
        end else begin
          cur_mode = MODE_STEPPER;
          step_cw  = val[0];
        end
      end
      default: bad = 1'b1;
    endcase

    if (run_on) begin
      case (cur_mode)
        MODE_MIRROR: drive = pins;
        MODE_LATCH:  drive = latch_val;
        MODE_CHASE: begin
          // A zero period makes every evaluated item rotate the pattern.
          if (chase_ticks >= chase_limit) begin
            chase_ticks = '0;
            chase_val   = {chase_val[6:0], chase_val[7]};
            chase_steps++;
          end
          drive = chase_val;
        end
        MODE_MANUAL: drive = manual_val;
        default: ;
      endcase
    end
    if (cur_mode == MODE_STEPPER) begin
      if (!run_on || !step_en) begin
        clear_pulse();
      end else if (step_ticks >= half_ticks) begin
        step_level = ~step_level;
        step_ticks = '0;
        pulse_edges++;
      end
      drive = 8'h00;
      drive[PULSE_POS] = step_level;
      drive[DIR_POS]   = step_cw;
      drive[ENA_POS]   = ~(step_en ^ ena_pol);
    end

    r.out_bits  = drive & OUT_MASK;
    r.running   = run_on;
    r.mode_now  = cur_mode;
    r.stepping  = run_on && cur_mode == MODE_STEPPER && step_en;
    r.cmd_error = bad;
    return r;
  endfunction

  // Offers one item; valid stays high on return so a gapless next item
  // follows with no gap in valid.
  task automatic send_item(input logic [3:0] act, input logic [7:0] pins,
                           input logic [7:0] val, input logic [3:0] idx);
    int gap;
    gap = src_gaps ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, idx, val, pins};
    do @(posedge clk); while (!s_tready);
    outputs_due.push_back(controller_outputs(act, pins, val, idx));
    items_sent++;
  endtask

  // Mostly well-formed commands with random operands, some raw noise.
  task automatic send_random_item();
    int         pick;
    logic [3:0] act;
    logic [7:0] pins;
    logic [7:0] val;
    logic [3:0] idx;
    pick = $urandom_range(0, 99);
    pins = 8'($urandom);
    val  = 8'($urandom);
    idx  = 4'($urandom);
    if (pick < 40) begin
      act = ACT_TICK;
    end else if (pick < 90) begin
      act = 4'($urandom_range(ACT_RUN_SET, ACT_STEP_DIR));
      case (act)
        ACT_RUN_SET, ACT_STEP_ENABLE, ACT_STEP_DIR: val = 8'($urandom_range(0, 1));
        ACT_MODE_SET: val = 8'($urandom_range(MODE_MIRROR, MODE_STEPPER));
        ACT_MANUAL_BIT: begin
          val = 8'($urandom_range(0, 1));
          idx = 4'($urandom_range(1, OUT_COUNT));
        end
        default: ;
      endcase
    end else begin
      act = 4'($urandom);
    end
    send_item(act, pins, val, idx);
  endtask

  // Waits until every expected result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outputs_due.size() != 0);
  endtask

  // Speed goes last so its divide does not overlap the other writes.
  task automatic configure(input logic [SPEED_W-1:0] speed, input logic [CHASE_W-1:0] period,
                           input logic pol);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_CHASE;
    cfg_data  <= period;
    @(posedge clk);
    cfg_index <= REG_ENA_POLART;
    cfg_data  <= CFG_W'(pol);
    @(posedge clk);
    cfg_index <= REG_SPEED;
    cfg_data  <= CFG_W'(speed);
    @(posedge clk);
    cfg_we    <= 1'b0;
    chase_limit = period;
    ena_pol     = pol;
    half_ticks  = half_for_speed(speed);
    clear_pulse();
    settings_used++;
  endtask

  task automatic stepper_burst(input int n);
    send_item(ACT_STEP_START, 8'($urandom), 8'($urandom), 4'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i % 97 == 96)
        send_item(ACT_STEP_DIR, 8'($urandom), 8'($urandom_range(0, 1)), 4'($urandom));
      else
        send_item(ACT_TICK, 8'($urandom), 8'($urandom), 4'($urandom));
    end
  endtask

  task automatic test_commands();
    send_item(ACT_TICK,         8'hFF, 8'hFF, 4'hF);  // stopped: outputs low
    send_item(ACT_RUN_SET,      8'hA5, 8'h01, 4'h0);
    send_item(ACT_LATCH,        8'h3C, 8'h00, 4'h0);
    send_item(ACT_NEXT_MODE,    8'hFF, 8'h00, 4'h0);
    send_item(ACT_NEXT_MODE,    8'h00, 8'h00, 4'h0);
    send_item(ACT_NEXT_MODE,    8'h5A, 8'h00, 4'h0);
    send_item(ACT_RUN_TOGGLE,   8'hFF, 8'h00, 4'h0);
    send_item(ACT_RUN_SET,      8'hFF, 8'h02, 4'h0);  // flag out of range
    send_item(ACT_MODE_SET,     8'h00, 8'h05, 4'h0);  // mode out of range
    send_item(ACT_MODE_SET,     8'h00, 8'hFF, 4'h0);
    send_item(ACT_MODE_SET,     8'h00, 8'h04, 4'h0);  // stepper while stopped
    send_item(ACT_MANUAL_WRITE, 8'h00, 8'hFF, 4'h0);
    send_item(ACT_MANUAL_BIT,   8'h00, 8'h00, 4'd1);
    send_item(ACT_MANUAL_BIT,   8'h00, 8'h00, 4'd8);
    send_item(ACT_MANUAL_BIT,   8'h00, 8'h01, 4'd0);  // index below range
    send_item(ACT_MANUAL_BIT,   8'h00, 8'h01, 4'd9);  // index above range
    send_item(ACT_MANUAL_BIT,   8'hFF, 8'h80, 4'd4);  // bit value not a flag
    send_item(ACT_STEP_DIR,     8'h00, 8'h00, 4'h0);
    send_item(ACT_STEP_ENABLE,  8'h00, 8'h00, 4'h0);
    send_item(ACT_STEP_ENABLE,  8'h00, 8'h03, 4'h0);
    send_item(ACT_RUN_SET,      8'h00, 8'h01, 4'h0);  // run in stepper mode re-enables
    send_item(ACT_STEP_STOP,    8'hFF, 8'h00, 4'h0);
    send_item(ACT_STEP_START,   8'h00, 8'h00, 4'h0);
    send_item(ACT_STEP_DIR,     8'h00, 8'h01, 4'hF);
    send_item(ACT_MODE_SET,     8'hC3, 8'h00, 4'h0);
    send_item(ACT_UNUSED_LO,    8'h00, 8'h01, 4'h1);
    send_item(ACT_UNUSED_HI,    8'hFF, 8'hFF, 4'hF);
  endtask

  // Fastest speeds keep the half period short enough to see the pulse flip.
  task automatic test_stepper_pulse();
    configure(SPEED_MAX, 20'd5, 1'b1);
    stepper_burst(520);
    configure(11'h7FF, 20'd0, 1'b0);
    stepper_burst(270);
  endtask

  task automatic test_random_traffic();
    logic [SPEED_W-1:0] speeds  [5];
    logic [CHASE_W-1:0] periods [5];
    logic               pols    [5];
    speeds  = '{11'd0, 11'h7FF, 11'd1000, SPEED_MIN, 11'd200};
    periods = '{20'd1000000, 20'd0, 20'd1, 20'd3, 20'd17};
    pols    = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    for (int p = 0; p < 5; p++) begin
      configure(speeds[p], periods[p], pols[p]);
      src_gaps  = (p != 1 && p != 3);
      sink_gaps = (p != 2 && p != 3);
      repeat (90) send_random_item();
    end
  endtask

  // The receiver stalls for a long stretch while items keep coming.
  task automatic test_backpressure();
    drain();
    src_gaps  = 1'b0;
    sink_gaps = 1'b1;
    sink_hold = 200;
    repeat (40) send_random_item();
    src_gaps = 1'b1;
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      if (errors < REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  // Receiver: draws a stall per result, or serves a requested long hold.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = sink_gaps ? $urandom_range(0, 15) : 0;
      if (sink_hold > 0) begin
        stall     = sink_hold;
        sink_hold = 0;
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (outputs_due.size() == 0) begin
        if (errors < REPORT_MAX)
          $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
        errors++;
      end else begin
        want = outputs_due.pop_front();
        check_field("out_bits", want.out_bits, m_tdata[7:0]);
        check_field("running", 8'(want.running), 8'(m_tdata[8]));
        check_field("mode_now", 8'(want.mode_now), 8'(m_tdata[11:9]));
        check_field("stepping", 8'(want.stepping), 8'(m_tdata[12]));
        check_field("cmd_error", 8'(want.cmd_error), 8'(m_tdata[13]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, outputs_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_commands();
    test_stepper_pulse();
    test_random_traffic();
    test_backpressure();
    drain();
    repeat (10) @(posedge clk);
    if (outputs_due.size() != 0) errors++;
    $display("Sent %0d items, checked %0d results under %0d register settings.",
             items_sent, results_seen, settings_used);
    $display("Predicted %0d chase rotations and %0d step pulse edges.",
             chase_steps, pulse_edges);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### sim.f
design/pomc_pkg.sv
design/pomc_div.sv
design/pomc_core.sv
design/plc_output_mode_controller.sv
test/plc_output_mode_controller_tb.sv
